FILE: hw/rtl/owrs_pkg.sv
// ----------------------------------------------------------------------------
// owrs_pkg
// Shared types and constants for the 1-Wire ROM search core.
// ----------------------------------------------------------------------------
package owrs_pkg;

  // rom code length and derived widths
  localparam int ROM_BITS = 64;
  localparam int POS_W    = $clog2(ROM_BITS + 1);
  localparam int IDX_W    = $clog2(ROM_BITS);
  localparam int ADDR_W   = 64;
  localparam int FAM_W    = 4;

  // positions below this limit fall in the family byte
  localparam int FAMILY_LIMIT = 9;

  // search command bytes
  localparam logic [7:0] CMD_NORMAL = 8'hF0;
  localparam logic [7:0] CMD_ALARM  = 8'hEC;

  // operation codes
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_TARGET = 2'd1;
  localparam logic [1:0] OP_BEGIN  = 2'd2;
  localparam logic [1:0] OP_BIT    = 2'd3;

  // status codes
  localparam logic [2:0] ST_DONE        = 3'd0;
  localparam logic [2:0] ST_FOUND       = 3'd1;
  localparam logic [2:0] ST_NO_PRESENCE = 3'd2;
  localparam logic [2:0] ST_NO_RESPONSE = 3'd3;
  localparam logic [2:0] ST_ZERO_FAMILY = 3'd4;
  localparam logic [2:0] ST_EXHAUSTED   = 3'd5;
  localparam logic [2:0] ST_IGNORED     = 3'd6;
  localparam logic [2:0] ST_SET         = 3'd7;

  // input item
  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] target_family;
    logic       presence;
    logic       normal_search;
    logic       id_bit;
    logic       complement_bit;
  } cmd_item_t;

  // result item
  typedef struct packed {
    logic [2:0]        status;
    logic              direction_bit;
    logic [7:0]        command_byte;
    logic [ADDR_W-1:0] rom_address;
    logic [FAM_W-1:0]  family_discrepancy_out;
    logic              last_device;
  } res_item_t;

endpackage

FILE: hw/rtl/one_wire_rom_search_core.sv
// ----------------------------------------------------------------------------
// one_wire_rom_search_core
// ROM search sequencer: one search event per item, one result per item.
// ----------------------------------------------------------------------------
//
//   channel | signals                            | direction | item type
//   --------+------------------------------------+-----------+-----------
//   cmd     | cmd_valid, cmd_stall, cmd_item     | in        | cmd_item_t
//   res     | res_valid, res_stall, res_item     | out       | res_item_t
//
// One item per cycle sustained while res is not stalled; a result is valid once its
// item has passed the input register and the decision logic into the result register.
// The search state is updated in the same cycle an item moves into the result
// register, so the next item always sees it.
// rst clears the search state and both valid flags.
// A stall on res holds the result and backs up into cmd_stall once the input
// register is also full.
//
module one_wire_rom_search_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  owrs_pkg::cmd_item_t cmd_item,
  output logic                res_valid,
  input  logic                res_stall,
  output owrs_pkg::res_item_t res_item
);
  import owrs_pkg::*;

  // pipeline registers
  logic      in_valid;
  cmd_item_t in_item;
  logic      advance;

  // search state
  logic [ROM_BITS-1:0] rom_bits;
  logic [POS_W-1:0]    last_discrepancy;
  logic [FAM_W-1:0]    family_discrepancy;
  logic                last_device_seen;
  logic [POS_W-1:0]    bit_position;
  logic [POS_W-1:0]    zero_branch_pos;
  logic                pass_active;

  logic [ROM_BITS-1:0] rom_bits_next;
  logic [POS_W-1:0]    last_discrepancy_next;
  logic [FAM_W-1:0]    family_discrepancy_next;
  logic                last_device_seen_next;
  logic [POS_W-1:0]    bit_position_next;
  logic [POS_W-1:0]    zero_branch_pos_next;
  logic                pass_active_next;
  res_item_t           res_next;

  logic [IDX_W-1:0]    idx;
  logic                dir;

  // handshake
  assign advance   = in_valid && (!res_valid || !res_stall);
  assign cmd_stall = in_valid && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd_valid && !cmd_stall) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
    if (cmd_valid && !cmd_stall) begin
      in_item <= cmd_item;
    end
  end

  // search decision for the held item
  assign idx = IDX_W'(bit_position - POS_W'(1));

  always_comb begin
    rom_bits_next           = rom_bits;
    last_discrepancy_next   = last_discrepancy;
    family_discrepancy_next = family_discrepancy;
    last_device_seen_next   = last_device_seen;
    bit_position_next       = bit_position;
    zero_branch_pos_next    = zero_branch_pos;
    pass_active_next        = pass_active;
    dir                     = 1'b0;
    res_next                = '0;
    res_next.status         = ST_IGNORED;

    case (in_item.operation)
      OP_CLEAR: begin
        rom_bits_next           = '0;
        last_discrepancy_next   = '0;
        family_discrepancy_next = '0;
        last_device_seen_next   = 1'b0;
        pass_active_next        = 1'b0;
        bit_position_next       = POS_W'(1);
        zero_branch_pos_next    = '0;
        res_next.status         = ST_SET;
      end
      OP_TARGET: begin
        rom_bits_next           = ROM_BITS'(in_item.target_family);
        last_discrepancy_next   = POS_W'(ROM_BITS);
        family_discrepancy_next = '0;
        last_device_seen_next   = 1'b0;
        pass_active_next        = 1'b0;
        bit_position_next       = POS_W'(1);
        zero_branch_pos_next    = '0;
        res_next.status         = ST_SET;
      end
      OP_BEGIN: begin
        pass_active_next        = 1'b0;
        bit_position_next       = POS_W'(1);
        zero_branch_pos_next    = '0;
        if (last_device_seen) begin
          last_discrepancy_next   = '0;
          family_discrepancy_next = '0;
          last_device_seen_next   = 1'b0;
          res_next.status         = ST_EXHAUSTED;
        end else if (!in_item.presence) begin
          last_discrepancy_next   = '0;
          family_discrepancy_next = '0;
          last_device_seen_next   = 1'b0;
          res_next.status         = ST_NO_PRESENCE;
        end else begin
          pass_active_next      = 1'b1;
          res_next.command_byte = in_item.normal_search ? CMD_NORMAL : CMD_ALARM;
          res_next.status       = ST_DONE;
        end
      end
      OP_BIT: begin
        if (pass_active) begin
          if (in_item.id_bit && in_item.complement_bit) begin
            // no device answered
            last_discrepancy_next   = '0;
            family_discrepancy_next = '0;
            last_device_seen_next   = 1'b0;
            pass_active_next        = 1'b0;
            bit_position_next       = POS_W'(1);
            zero_branch_pos_next    = '0;
            res_next.status         = ST_NO_RESPONSE;
          end else begin
            // pick the direction for this position
            if (in_item.id_bit != in_item.complement_bit) begin
              dir = in_item.id_bit;
            end else begin
              if (bit_position < last_discrepancy) begin
                dir = rom_bits[idx];
              end else begin
                dir = (bit_position == last_discrepancy);
              end
              if (!dir) begin
                zero_branch_pos_next = bit_position;
                if (bit_position < POS_W'(FAMILY_LIMIT)) begin
                  family_discrepancy_next = FAM_W'(bit_position);
                end
              end
            end
            rom_bits_next[idx]     = dir;
            bit_position_next      = bit_position + POS_W'(1);
            res_next.status        = ST_DONE;
            res_next.direction_bit = dir;

            // last position closes the pass
            if (bit_position >= POS_W'(ROM_BITS)) begin
              last_discrepancy_next   = zero_branch_pos_next;
              last_device_seen_next   = (zero_branch_pos_next == '0);
              pass_active_next        = 1'b0;
              bit_position_next       = POS_W'(1);
              zero_branch_pos_next    = '0;
              res_next.direction_bit  = 1'b0;
              if (rom_bits_next[7:0] == 8'd0) begin
                last_discrepancy_next   = '0;
                family_discrepancy_next = '0;
                last_device_seen_next   = 1'b0;
                res_next.status         = ST_ZERO_FAMILY;
              end else begin
                res_next.status      = ST_FOUND;
                res_next.rom_address = ADDR_W'(rom_bits_next);
              end
            end
          end
        end
      end
      default: begin
        res_next.status = ST_IGNORED;
      end
    endcase

    res_next.family_discrepancy_out = family_discrepancy_next;
    res_next.last_device            = last_device_seen_next;
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rom_bits           <= '0;
      last_discrepancy   <= '0;
      family_discrepancy <= '0;
      last_device_seen   <= 1'b0;
      bit_position       <= POS_W'(1);
      zero_branch_pos    <= '0;
      pass_active        <= 1'b0;
      res_valid          <= 1'b0;
    end else begin
      if (advance) begin
        rom_bits           <= rom_bits_next;
        last_discrepancy   <= last_discrepancy_next;
        family_discrepancy <= family_discrepancy_next;
        last_device_seen   <= last_device_seen_next;
        bit_position       <= bit_position_next;
        zero_branch_pos    <= zero_branch_pos_next;
        pass_active        <= pass_active_next;
        res_valid          <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
    if (advance) begin
      res_item <= res_next;
    end
  end

  // idle search keeps the pass counters at their start values
  a_idle_pass: assert property (@(posedge clk) disable iff (rst)
    !pass_active |-> (bit_position == POS_W'(1)) && (zero_branch_pos == '0))
    else $error("pass counters moved outside a pass");

  // a found rom code always carries a nonzero family byte
  a_found_family: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_item.status == ST_FOUND) |-> (res_item.rom_address[7:0] != 8'd0))
    else $error("found result with zero family byte");

  // a command byte only comes with a started pass
  a_cmd_pass: assert property (@(posedge clk) disable iff (rst)
    advance && (res_next.command_byte != 8'd0) |=> pass_active)
    else $error("command byte issued without an active pass");

  // discrepancy never points past the rom code
  a_disc_range: assert property (@(posedge clk) disable iff (rst)
    last_discrepancy <= POS_W'(ROM_BITS))
    else $error("last discrepancy out of range");

  // the input register is never overwritten while it still holds an item
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_item))
    else $error("held item lost");

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Checks the 1-Wire ROM search core. A short directed run comes first. Then
// search sessions run against a modeled population of bus devices, with
// random noise items mixed in. Every result is compared field by field with
// an in-bench model of the search state.
// ---------------------------------------------------------------------------
module testbench;
  import owrs_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int WORK_TARGET = 1450;

  // search state mirror and store of pending results
  class rom_search_tracker;
    logic [63:0] rom_code;
    logic [6:0]  last_disc;
    logic [3:0]  fam_disc;
    logic        last_dev;
    logic [6:0]  bit_pos;
    logic [6:0]  zero_branch;
    logic        in_pass;
    res_item_t   expected_q[$];
    int          errors;
    int          found;
    int          exhausted;

    function new();
      rom_code = '0;
      forget();
      close_pass();
      errors = 0;
      found = 0;
      exhausted = 0;
    endfunction

    function void forget();
      last_disc = '0;
      fam_disc = '0;
      last_dev = 1'b0;
    endfunction

    function void close_pass();
      in_pass = 1'b0;
      bit_pos = 7'd1;
      zero_branch = '0;
    endfunction

    // update the state for one accepted item and queue its result
    function res_item_t take_command(cmd_item_t c);
      res_item_t r;
      logic [6:0] pos;
      int idx;
      logic dir;
      r = '0;
      r.status = ST_IGNORED;
      case (c.operation)
        OP_CLEAR: begin
          rom_code = '0;
          forget();
          close_pass();
          r.status = ST_SET;
        end
        OP_TARGET: begin
          rom_code = {56'd0, c.target_family};
          forget();
          last_disc = 7'(ROM_BITS);
          close_pass();
          r.status = ST_SET;
        end
        OP_BEGIN: begin
          close_pass();
          if (last_dev) begin
            forget();
            r.status = ST_EXHAUSTED;
            exhausted++;
          end else if (!c.presence) begin
            forget();
            r.status = ST_NO_PRESENCE;
          end else begin
            in_pass = 1'b1;
            r.command_byte = c.normal_search ? CMD_NORMAL : CMD_ALARM;
            r.status = ST_DONE;
          end
        end
        OP_BIT: begin
          if (in_pass && c.id_bit && c.complement_bit) begin
            // nobody answered
            forget();
            close_pass();
            r.status = ST_NO_RESPONSE;
          end else if (in_pass) begin
            pos = bit_pos;
            idx = int'(pos) - 1;
            if (c.id_bit != c.complement_bit) begin
              dir = c.id_bit;
            end else begin
              // conflict: follow the previous path below the last discrepancy
              if (pos < last_disc) dir = rom_code[idx];
              else dir = (pos == last_disc);
              if (!dir) begin
                zero_branch = pos;
                if (pos < FAMILY_LIMIT) fam_disc = pos[3:0];
              end
            end
            rom_code[idx] = dir;
            bit_pos = pos + 7'd1;
            r.status = ST_DONE;
            r.direction_bit = dir;
            // pass end
            if (pos >= ROM_BITS) begin
              last_disc = zero_branch;
              last_dev = (zero_branch == 7'd0);
              close_pass();
              r.direction_bit = 1'b0;
              if (rom_code[7:0] == 8'd0) begin
                forget();
                r.status = ST_ZERO_FAMILY;
              end else begin
                r.status = ST_FOUND;
                r.rom_address = rom_code;
                found++;
              end
            end
          end
        end
        default: ;
      endcase
      r.family_discrepancy_out = fam_disc;
      r.last_device = last_dev;
      expected_q.push_back(r);
      return r;
    endfunction

    function void check_field(string what, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %h got %h", $time, what, want, got);
      end
    endfunction

    // compare one accepted result with the oldest pending one
    function void check_result(res_item_t got);
      res_item_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing pending, expected none got %h", $time, got);
        return;
      end
      want = expected_q.pop_front();
      check_field("status", 64'(want.status), 64'(got.status));
      check_field("direction_bit", 64'(want.direction_bit), 64'(got.direction_bit));
      check_field("command_byte", 64'(want.command_byte), 64'(got.command_byte));
      check_field("rom_address", want.rom_address, got.rom_address);
      check_field("family_discrepancy_out", 64'(want.family_discrepancy_out),
                  64'(got.family_discrepancy_out));
      check_field("last_device", 64'(want.last_device), 64'(got.last_device));
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      cmd_valid;
  logic      cmd_stall;
  cmd_item_t cmd_item;
  logic      res_valid;
  logic      res_stall;
  res_item_t res_item;

  rom_search_tracker tracker;
  int cmd_gap_max = 10;
  int res_gap_max = 10;
  int work_items = 0;
  int sessions = 0;
  int cycle_count = 0;

  // modeled devices on the bus
  logic [63:0] devices[$];
  bit          alarming[$];

  one_wire_rom_search_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_item  (cmd_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

  // clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  function automatic cmd_item_t make_cmd(logic [1:0] op, logic [7:0] fam, logic pres,
                                         logic norm, logic idb, logic cmpb);
    cmd_item_t c;
    c.operation = op;
    c.target_family = fam;
    c.presence = pres;
    c.normal_search = norm;
    c.id_bit = idb;
    c.complement_bit = cmpb;
    return c;
  endfunction

  function automatic cmd_item_t random_cmd();
    return make_cmd(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom),
                    1'($urandom), 1'($urandom), 1'($urandom));
  endfunction

  // present one item after a random gap and hold it until taken
  task automatic send_cmd(input cmd_item_t c, output res_item_t predicted);
    int gap;
    gap = $urandom_range(0, cmd_gap_max);
    repeat (gap) begin
      @(negedge clk);
      cmd_valid <= 1'b0;
    end
    @(negedge clk);
    cmd_valid <= 1'b1;
    cmd_item <= c;
    do @(posedge clk); while (cmd_stall);
    predicted = tracker.take_command(c);
    if (predicted.status != ST_IGNORED) work_items++;
  endtask

  // hold off the sender until every pending result is back
  task automatic wait_for_results();
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (tracker.expected_q.size() != 0) @(posedge clk);
  endtask

  // one pass against the modeled bus: begin, then up to 64 bit pairs
  task automatic run_pass(output res_item_t last);
    bit listening[$];
    logic idb;
    logic cmpb;
    bit normal;
    normal = ($urandom_range(0, 3) != 0);
    send_cmd(make_cmd(OP_BEGIN, 8'($urandom), ($urandom_range(0, 19) != 0), normal,
                      1'($urandom), 1'($urandom)), last);
    if (last.status != ST_DONE) return;
    foreach (devices[i]) listening.push_back(normal || alarming[i]);
    for (int pos = 0; pos < 64; pos++) begin
      // rare stray item breaks the pass
      if ($urandom_range(0, 299) == 0) begin
        send_cmd(random_cmd(), last);
        return;
      end
      // wired-and of every selected device
      idb = 1'b1;
      cmpb = 1'b1;
      foreach (devices[i]) begin
        if (listening[i]) begin
          idb &= devices[i][pos];
          cmpb &= ~devices[i][pos];
        end
      end
      send_cmd(make_cmd(OP_BIT, 8'($urandom), 1'($urandom), 1'($urandom), idb, cmpb),
               last);
      if (last.status != ST_DONE) return;
      foreach (devices[i]) begin
        if (devices[i][pos] != last.direction_bit) listening[i] = 1'b0;
      end
    end
  endtask

  // new device population, then passes until the search runs out or ndev + 3 passes are done
  task automatic search_session();
    int ndev;
    int passes;
    int share;
    logic [63:0] code;
    logic [63:0] mask;
    logic [7:0] fam;
    res_item_t p;
    devices.delete();
    alarming.delete();
    ndev = $urandom_range(1, 4);
    repeat (ndev) begin
      code = {$urandom, $urandom};
      // shared low bits push discrepancies deep into the code
      if (devices.size() > 0 && $urandom_range(0, 1) == 1) begin
        share = $urandom_range(1, 63);
        mask = (64'd1 << share) - 64'd1;
        code = (devices[$] & mask) | (code & ~mask);
      end
      if ($urandom_range(0, 19) == 0) code[7:0] = 8'd0;
      devices.push_back(code);
      alarming.push_back(1'($urandom));
    end
    if ($urandom_range(0, 3) == 0) begin
      fam = $urandom_range(0, 1) ? devices[$urandom_range(0, ndev - 1)][7:0] : 8'($urandom);
      send_cmd(make_cmd(OP_TARGET, fam, 1'($urandom), 1'($urandom), 1'($urandom),
                        1'($urandom)), p);
    end else begin
      send_cmd(make_cmd(OP_CLEAR, 8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                        1'($urandom)), p);
    end
    passes = 0;
    do begin
      run_pass(p);
      passes++;
    end while (p.status != ST_EXHAUSTED && passes < ndev + 3);
    sessions++;
  endtask

  // result side: random stall before each item
  initial begin
    int n;
    res_stall = 1'b0;
    wait (rst === 1'b0);
    forever begin
      n = $urandom_range(0, res_gap_max);
      repeat (n) begin
        @(negedge clk);
        res_stall <= 1'b1;
      end
      @(negedge clk);
      res_stall <= 1'b0;
      do @(posedge clk); while (!res_valid);
      tracker.check_result(res_item);
    end
  end

  // stimulus
  initial begin
    res_item_t p;
    tracker = new();
    rst = 1'b1;
    cmd_valid = 1'b0;
    cmd_item = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: idle bit pair, failed begin, targets, restart, all bit pairs
    send_cmd(make_cmd(OP_BIT, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0), p);
    send_cmd(make_cmd(OP_BEGIN, 8'hFF, 1'b0, 1'b1, 1'b1, 1'b1), p);
    send_cmd(make_cmd(OP_CLEAR, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0), p);
    send_cmd(make_cmd(OP_TARGET, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1), p);
    send_cmd(make_cmd(OP_TARGET, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0), p);
    send_cmd(make_cmd(OP_BEGIN, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0), p);
    send_cmd(make_cmd(OP_BEGIN, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0), p);
    send_cmd(make_cmd(OP_BIT, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1), p);
    send_cmd(make_cmd(OP_BIT, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b0), p);
    send_cmd(make_cmd(OP_BIT, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0), p);
    send_cmd(make_cmd(OP_BIT, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0), p);
    send_cmd(make_cmd(OP_TARGET, 8'hA5, 1'b0, 1'b0, 1'b0, 1'b0), p);
    send_cmd(make_cmd(OP_BEGIN, 8'h5A, 1'b1, 1'b1, 1'b0, 1'b0), p);
    send_cmd(make_cmd(OP_BIT, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0), p);
    send_cmd(make_cmd(OP_BIT, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0), p);
    send_cmd(make_cmd(OP_BIT, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1), p);
    send_cmd(make_cmd(OP_BIT, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b1), p);
    send_cmd(make_cmd(OP_TARGET, 8'h5A, 1'b1, 1'b0, 1'b1, 1'b0), p);
    send_cmd(make_cmd(OP_BEGIN, 8'h00, 1'b1, 1'b0, 1'b1, 1'b1), p);
    send_cmd(make_cmd(OP_BIT, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0), p);
    send_cmd(make_cmd(OP_CLEAR, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1), p);
    wait_for_results();

    // random: mostly full search sessions, some noise
    while (work_items < WORK_TARGET) begin
      cmd_gap_max = ($urandom_range(0, 4) == 0) ? 0 : 10;
      res_gap_max = ($urandom_range(0, 4) == 0) ? 0 : 10;
      if ($urandom_range(0, 4) != 0) begin
        search_session();
      end else begin
        repeat ($urandom_range(1, 8)) send_cmd(random_cmd(), p);
      end
      if ($urandom_range(0, 9) == 0) wait_for_results();
    end

    wait_for_results();
    repeat (8) @(posedge clk);
    $display("covered %0d working items over %0d search sessions", work_items, sessions);
    $display("devices found %0d times, search ran out %0d times",
             tracker.found, tracker.exhausted);
    if (tracker.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/owrs_pkg.sv
hw/rtl/one_wire_rom_search_core.sv
bench/testbench.sv
